FILE: sv/cpt_pkg.sv
// Shared types and constants of the client ping table.
package cpt_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned KEY_W   = ADDR_W + PORT_W;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_FIND   = 3'd0,
    FN_ADD    = 3'd1,
    FN_RESET  = 3'd2,
    FN_REMOVE = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

endpackage

FILE: sv/cpt_req_if.sv
// Request channel: operation and client key.
interface cpt_req_if;
  logic                       valid;
  logic                       ready;
  logic [cpt_pkg::FUNC_W-1:0] func;
  logic [cpt_pkg::ADDR_W-1:0] addr;
  logic [cpt_pkg::PORT_W-1:0] port;

  modport source (output valid, func, addr, port, input ready);
  modport sink   (input valid, func, addr, port, output ready);
endinterface

FILE: sv/cpt_rsp_if.sv
// Response channel: hit, count, status and occupancy.
interface cpt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [cpt_pkg::TOTAL_W-1:0] ping_total;
  logic [cpt_pkg::STAT_W-1:0]  status;
  logic [cpt_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, hit, ping_total, status, occupancy, input ready);
  modport sink   (input valid, hit, ping_total, status, occupancy, output ready);
endinterface

FILE: sv/cpt_ram.sv
// Generic simple dual-port RAM with registered read.
module cpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/client_ping_table.sv
// Client ping table: keyed client table with saturating ping counters.
//
//   channel | dir | payload                                  | accepted when
//   req_i   | in  | func, addr, port                         | valid && ready
//   rsp_o   | out | hit, ping_total, status, occupancy       | valid && ready
//
// A request runs the key scan, then an update step, then the response write,
// leaving the scan early on a key hit: the key scan reads one entry per cycle
// from the entry RAM through one key comparator. Clear skips to the response
// write. req_i.ready returns in the cycle after the response register loads.
// Reset clears all valid bits and the occupancy at once; no sweep.
// The response register holds a result until taken; a stalled response
// stalls the next request only at its final write into that register.
module client_ping_table #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cpt_req_if.sink   req_i,
  cpt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ENTRY_W = cpt_pkg::KEY_W + COUNT_BITS;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_e;

  state_e                       state_q;
  logic [cpt_pkg::FUNC_W-1:0]   func_q;
  logic [cpt_pkg::ADDR_W-1:0]   addr_q;
  logic [cpt_pkg::PORT_W-1:0]   port_q;
  logic [ENTRIES-1:0]           valid_q;
  logic [CNT_W-1:0]             occ_q;
  logic [IDX_W-1:0]             scan_idx_q;
  logic                         issue_done_q;
  logic                         cmp_valid_q;
  logic [IDX_W-1:0]             cmp_idx_q;
  logic                         hit_q;
  logic [IDX_W-1:0]             sel_idx_q;
  logic                         free_found_q;
  logic [IDX_W-1:0]             free_idx_q;
  logic [COUNT_BITS-1:0]        cnt_q;
  logic                         res_hit_q;
  logic [COUNT_BITS-1:0]        res_cnt_q;
  cpt_pkg::status_e             res_status_q;
  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [cpt_pkg::TOTAL_W-1:0]  out_total_q;
  cpt_pkg::status_e             out_status_q;
  logic [cpt_pkg::OCC_W-1:0]    out_occ_q;

  logic                         rd_en;
  logic [ENTRY_W-1:0]           rd_data;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [ENTRY_W-1:0]           wr_data;
  logic [COUNT_BITS-1:0]        wr_count;
  logic [COUNT_BITS-1:0]        cnt_inc;
  logic                         key_match;
  logic [31:0]                  occ_wide;
  logic [63:0]                  cnt_wide;
  logic                         res_hit_d;
  logic [COUNT_BITS-1:0]        res_cnt_d;
  cpt_pkg::status_e             res_status_d;

  cpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_data)
  );

  assign rd_en     = (state_q == S_SCAN) && !issue_done_q;
  assign key_match = valid_q[cmp_idx_q] &&
                     (rd_data[ENTRY_W-1:COUNT_BITS] == {addr_q, port_q});
  assign cnt_inc   = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign occ_wide  = 32'(occ_q);
  assign cnt_wide  = 64'(res_cnt_q);

  always_comb begin
    wr_count = '0;
    if (func_q == cpt_pkg::FN_ADD) begin
      wr_count = hit_q ? cnt_inc : COUNT_BITS'(1);
    end
    wr_en   = (state_q == S_UPDATE) &&
              (((func_q == cpt_pkg::FN_ADD) && (hit_q || free_found_q)) ||
               ((func_q == cpt_pkg::FN_RESET) && hit_q));
    wr_addr = hit_q ? sel_idx_q : free_idx_q;
    wr_data = {addr_q, port_q, wr_count};
  end

  always_comb begin
    res_hit_d    = hit_q;
    res_cnt_d    = '0;
    res_status_d = hit_q ? cpt_pkg::STAT_OK : cpt_pkg::STAT_MISS;
    case (func_q) inside
      cpt_pkg::FN_ADD: begin
        if (hit_q) begin
          res_cnt_d = cnt_inc;
        end else if (free_found_q) begin
          res_hit_d    = 1'b1;
          res_cnt_d    = COUNT_BITS'(1);
          res_status_d = cpt_pkg::STAT_OK;
        end else begin
          res_status_d = cpt_pkg::STAT_FULL;
        end
      end
      cpt_pkg::FN_RESET, cpt_pkg::FN_REMOVE: begin
      end
      default: begin
        if (hit_q) begin
          res_cnt_d = cnt_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= '0;
      addr_q       <= '0;
      port_q       <= '0;
      valid_q      <= '0;
      occ_q        <= '0;
      scan_idx_q   <= '0;
      issue_done_q <= 1'b0;
      cmp_valid_q  <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      sel_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      cnt_q        <= '0;
      res_hit_q    <= 1'b0;
      res_cnt_q    <= '0;
      res_status_q <= cpt_pkg::STAT_OK;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_total_q  <= '0;
      out_status_q <= cpt_pkg::STAT_OK;
      out_occ_q    <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            func_q       <= req_i.func;
            addr_q       <= req_i.addr;
            port_q       <= req_i.port;
            scan_idx_q   <= '0;
            issue_done_q <= 1'b0;
            cmp_valid_q  <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            if (req_i.func == cpt_pkg::FN_CLEAR) begin
              valid_q      <= '0;
              occ_q        <= '0;
              res_hit_q    <= 1'b0;
              res_cnt_q    <= '0;
              res_status_q <= cpt_pkg::STAT_OK;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_valid_q <= !issue_done_q;
          cmp_idx_q   <= scan_idx_q;
          if (!issue_done_q) begin
            if (scan_idx_q == LastIdx) begin
              issue_done_q <= 1'b1;
            end else begin
              scan_idx_q <= scan_idx_q + IDX_W'(1);
            end
          end
          if (cmp_valid_q) begin
            if (key_match) begin
              hit_q     <= 1'b1;
              sel_idx_q <= cmp_idx_q;
              cnt_q     <= rd_data[COUNT_BITS-1:0];
              state_q   <= S_UPDATE;
            end else begin
              if (!valid_q[cmp_idx_q] && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= cmp_idx_q;
              end
              if (cmp_idx_q == LastIdx) begin
                state_q <= S_UPDATE;
              end
            end
          end
        end
        S_UPDATE: begin
          res_hit_q    <= res_hit_d;
          res_cnt_q    <= res_cnt_d;
          res_status_q <= res_status_d;
          case (func_q)
            cpt_pkg::FN_ADD: begin
              if (!hit_q && free_found_q) begin
                valid_q[free_idx_q] <= 1'b1;
                occ_q               <= occ_q + CNT_W'(1);
              end
            end
            cpt_pkg::FN_REMOVE: begin
              if (hit_q) begin
                valid_q[sel_idx_q] <= 1'b0;
                occ_q              <= occ_q - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_hit_q    <= res_hit_q;
            out_total_q  <= cnt_wide[cpt_pkg::TOTAL_W-1:0];
            out_status_q <= res_status_q;
            out_occ_q    <= occ_wide[cpt_pkg::OCC_W-1:0];
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.ping_total = out_total_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.occupancy  = out_occ_q;

endmodule

FILE: sv/cpt_checker.sv
// Port-level assertions for the client ping table, with its bind.
module cpt_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_hit_i,
  input logic [cpt_pkg::TOTAL_W-1:0] rsp_ping_total_i,
  input logic [cpt_pkg::STAT_W-1:0]  rsp_status_i,
  input logic [cpt_pkg::OCC_W-1:0]   rsp_occupancy_i
);

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while a request is in progress");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i) &&
      $stable(rsp_ping_total_i) && $stable(rsp_status_i) && $stable(rsp_occupancy_i))
    else $error("stalled response changed");

  a_fail_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != cpt_pkg::STAT_OK) |->
      !rsp_hit_i && (rsp_ping_total_i == '0))
    else $error("failed request reports a hit or a count");

  a_full_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == cpt_pkg::STAT_FULL) |->
      (rsp_occupancy_i == cpt_pkg::OCC_W'(ENTRIES)))
    else $error("full status with free entries");

  a_occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(rsp_occupancy_i) <= 32'(ENTRIES)))
    else $error("occupancy above table size");

endmodule

bind client_ping_table cpt_checker #(
  .ENTRIES (ENTRIES)
) u_cpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_hit_i        (rsp_o.hit),
  .rsp_ping_total_i (rsp_o.ping_total),
  .rsp_status_i     (rsp_o.status),
  .rsp_occupancy_i  (rsp_o.occupancy)
);

FILE: dv/tb.sv
// Self-checking testbench for the client ping table: keyed lookups, counters and occupancy.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned CNT_BITS    = 32;
  localparam int unsigned POOL        = 24;
  localparam int unsigned ITEMS       = 1350;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTS  = 100;
  localparam int unsigned HAMMER_ADDS = 40;

  localparam logic [cpt_pkg::FUNC_W-1:0] FN_SPARE0 = 3'd5;
  localparam logic [cpt_pkg::FUNC_W-1:0] FN_SPARE1 = 3'd6;
  localparam logic [cpt_pkg::FUNC_W-1:0] FN_SPARE2 = 3'd7;

  typedef struct packed {
    logic                        hit;
    logic [cpt_pkg::TOTAL_W-1:0] ping_total;
    cpt_pkg::status_e            status;
    logic [cpt_pkg::OCC_W-1:0]   occupancy;
  } ping_rsp_t;

  typedef struct packed {
    logic [cpt_pkg::ADDR_W-1:0] addr;
    logic [cpt_pkg::PORT_W-1:0] port;
  } client_key_t;

  class ping_ledger;
    bit                         live     [ENTRIES];
    bit [cpt_pkg::ADDR_W-1:0]   key_addr [ENTRIES];
    bit [cpt_pkg::PORT_W-1:0]   key_port [ENTRIES];
    bit [CNT_BITS-1:0]          tally    [ENTRIES];
    int unsigned                n_live;
    ping_rsp_t                  due [$];
    int unsigned                errors;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      n_live = 0;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int find_slot(bit [cpt_pkg::ADDR_W-1:0] a, bit [cpt_pkg::PORT_W-1:0] p);
      int i;
      for (i = 0; i < ENTRIES; i++) begin
        if (live[i] && key_addr[i] == a && key_port[i] == p) return i;
      end
      return -1;
    endfunction

    function int lowest_free();
      int i;
      for (i = 0; i < ENTRIES; i++) begin
        if (!live[i]) return i;
      end
      return -1;
    endfunction

    function void note_request(bit [cpt_pkg::FUNC_W-1:0] fn, bit [cpt_pkg::ADDR_W-1:0] a,
                               bit [cpt_pkg::PORT_W-1:0] p);
      ping_rsp_t r;
      int        idx;
      int        i;
      r.hit        = 1'b0;
      r.ping_total = '0;
      r.status     = cpt_pkg::STAT_OK;
      idx          = find_slot(a, p);
      case (fn)
        cpt_pkg::FN_CLEAR: begin
          for (i = 0; i < ENTRIES; i++) live[i] = 1'b0;
          n_live = 0;
        end
        cpt_pkg::FN_ADD: begin
          if (idx < 0) begin
            idx = lowest_free();
            if (idx >= 0) begin
              live[idx]     = 1'b1;
              key_addr[idx] = a;
              key_port[idx] = p;
              tally[idx]    = '0;
              n_live++;
            end
          end
          if (idx >= 0) begin
            if (tally[idx] != {CNT_BITS{1'b1}}) tally[idx]++;
            r.hit        = 1'b1;
            r.ping_total = cpt_pkg::TOTAL_W'(tally[idx]);
          end else begin
            r.status = cpt_pkg::STAT_FULL;
          end
        end
        cpt_pkg::FN_RESET: begin
          if (idx >= 0) begin
            tally[idx] = '0;
            r.hit      = 1'b1;
          end else begin
            r.status = cpt_pkg::STAT_MISS;
          end
        end
        cpt_pkg::FN_REMOVE: begin
          if (idx >= 0) begin
            live[idx] = 1'b0;
            if (n_live > 0) n_live--;
            r.hit = 1'b1;
          end else begin
            r.status = cpt_pkg::STAT_MISS;
          end
        end
        default: begin
          if (idx >= 0) begin
            r.hit        = 1'b1;
            r.ping_total = cpt_pkg::TOTAL_W'(tally[idx]);
          end else begin
            r.status = cpt_pkg::STAT_MISS;
          end
        end
      endcase
      r.occupancy = cpt_pkg::OCC_W'(n_live);
      due.push_back(r);
    endfunction

    task check_response(ping_rsp_t got);
      ping_rsp_t want;
      if (due.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        want = due.pop_front();
        if (got.hit !== want.hit)
          report($sformatf("hit %b, want %b", got.hit, want.hit));
        if (got.ping_total !== want.ping_total)
          report($sformatf("ping_total %0h, want %0h", got.ping_total, want.ping_total));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.occupancy !== want.occupancy)
          report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  cpt_req_if req ();
  cpt_rsp_if rsp ();

  client_ping_table #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  ping_ledger  ledger = new();
  client_key_t pool [POOL];
  int unsigned sent;
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5ns clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : rsp_ready_drive
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : rsp_monitor
    ping_rsp_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got.hit        = rsp.hit;
        got.ping_total = rsp.ping_total;
        got.status     = cpt_pkg::status_e'(rsp.status);
        got.occupancy  = rsp.occupancy;
        ledger.check_response(got);
      end
    end
  end

  task automatic send_req(input logic [cpt_pkg::FUNC_W-1:0] fn, input client_key_t k);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.func  <= fn;
    req.addr  <= k.addr;
    req.port  <= k.port;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    ledger.note_request(fn, k.addr, k.port);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.due.size() != 0) @(posedge clk_i);
  endtask

  function automatic client_key_t random_key();
    client_key_t k;
    k.addr = $urandom;
    k.port = $urandom_range(0, 65535);
    return k;
  endfunction

  function automatic client_key_t make_key(logic [cpt_pkg::ADDR_W-1:0] a,
                                           logic [cpt_pkg::PORT_W-1:0] p);
    client_key_t k;
    k.addr = a;
    k.port = p;
    return k;
  endfunction

  task automatic new_pool();
    int unsigned i;
    for (i = 0; i < POOL; i++) begin
      pool[i] = random_key();
      if (i > 0) begin
        case ($urandom_range(0, 3))
          0: pool[i].addr = pool[i-1].addr;
          1: pool[i].port = pool[i-1].port;
          default: ;
        endcase
      end
    end
  endtask

  task automatic shuffle_gaps();
    src_gaps  = ($urandom_range(0, 3) != 0);
    sink_gaps = ($urandom_range(0, 3) != 0);
  endtask

  task automatic churn(input int unsigned n);
    int unsigned                i;
    int unsigned                r;
    logic [cpt_pkg::FUNC_W-1:0] fn;
    client_key_t                k;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      fn = cpt_pkg::FN_ADD;
      else if (r < 62) fn = cpt_pkg::FN_FIND;
      else if (r < 72) fn = cpt_pkg::FN_RESET;
      else if (r < 87) fn = cpt_pkg::FN_REMOVE;
      else if (r < 89) fn = cpt_pkg::FN_CLEAR;
      else if (r < 90) fn = FN_SPARE0;
      else if (r < 91) fn = FN_SPARE1;
      else if (r < 92) fn = FN_SPARE2;
      else             fn = cpt_pkg::FN_FIND;
      if ($urandom_range(0, 9) == 0) k = random_key();
      else k = pool[$urandom_range(0, POOL - 1)];
      send_req(fn, k);
    end
  endtask

  task automatic fill_up();
    int unsigned i;
    send_req(cpt_pkg::FN_CLEAR, random_key());
    for (i = 0; i < ENTRIES + 4; i++) send_req(cpt_pkg::FN_ADD, pool[i % POOL]);
    for (i = 0; i < 6; i++) send_req(cpt_pkg::FN_ADD, pool[$urandom_range(0, POOL - 1)]);
    send_req(cpt_pkg::FN_REMOVE, pool[$urandom_range(0, ENTRIES - 1)]);
    send_req(cpt_pkg::FN_ADD, pool[ENTRIES + $urandom_range(0, POOL - ENTRIES - 1)]);
    send_req(cpt_pkg::FN_ADD, pool[$urandom_range(0, POOL - 1)]);
  endtask

  task automatic noise(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_req(cpt_pkg::FUNC_W'($urandom_range(0, 7)), random_key());
  endtask

  task automatic hammer();
    int unsigned i;
    client_key_t k;
    k = pool[$urandom_range(0, POOL - 1)];
    send_req(cpt_pkg::FN_CLEAR, random_key());
    send_req(cpt_pkg::FN_ADD, pool[0]);
    for (i = 0; i < HAMMER_ADDS; i++) send_req(cpt_pkg::FN_ADD, k);
    send_req(cpt_pkg::FN_FIND, k);
    send_req(cpt_pkg::FN_RESET, k);
    send_req(cpt_pkg::FN_FIND, k);
    send_req(cpt_pkg::FN_ADD, k);
  endtask

  task automatic directed();
    client_key_t k_lo;
    client_key_t k_hi;
    client_key_t k_mix0;
    client_key_t k_mix1;
    k_lo   = make_key('0, '0);
    k_hi   = make_key('1, '1);
    k_mix0 = make_key('0, '1);
    k_mix1 = make_key('1, '0);
    send_req(cpt_pkg::FN_CLEAR, k_lo);
    send_req(cpt_pkg::FN_FIND, k_lo);
    send_req(cpt_pkg::FN_REMOVE, k_lo);
    send_req(cpt_pkg::FN_RESET, k_lo);
    send_req(cpt_pkg::FN_ADD, k_lo);
    send_req(cpt_pkg::FN_ADD, k_lo);
    send_req(cpt_pkg::FN_FIND, k_lo);
    send_req(cpt_pkg::FN_ADD, k_hi);
    send_req(cpt_pkg::FN_FIND, k_mix0);
    send_req(cpt_pkg::FN_FIND, k_mix1);
    send_req(cpt_pkg::FN_RESET, k_lo);
    send_req(cpt_pkg::FN_FIND, k_lo);
    send_req(FN_SPARE0, k_hi);
    send_req(FN_SPARE1, k_hi);
    send_req(FN_SPARE2, k_lo);
    send_req(cpt_pkg::FN_REMOVE, k_lo);
    send_req(cpt_pkg::FN_REMOVE, k_lo);
    send_req(cpt_pkg::FN_ADD, k_mix0);
    send_req(cpt_pkg::FN_ADD, k_mix1);
    send_req(cpt_pkg::FN_FIND, k_hi);
    send_req(cpt_pkg::FN_CLEAR, k_hi);
    send_req(cpt_pkg::FN_FIND, k_hi);
    send_req(cpt_pkg::FN_ADD, k_hi);
  endtask

  initial begin : stimulus
    bit          pressed;
    bit          hammered;
    int unsigned pick;
    pressed   = 1'b0;
    hammered  = 1'b0;
    sent      = 0;
    hold_req  = 1'b0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    rst_ni    <= 1'b0;
    req.valid <= 1'b0;
    req.func  <= cpt_pkg::FN_FIND;
    req.addr  <= '0;
    req.port  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    drain();

    new_pool();
    fill_up();
    while (sent < ITEMS - TAIL_ITEMS) begin
      shuffle_gaps();
      pick = $urandom_range(0, 9);
      if (!pressed && sent > 200) begin
        hold_req = 1'b1;
        churn(40);
        pressed = 1'b1;
      end else if (!hammered && sent > 400) begin
        drain();
        hammer();
        hammered = 1'b1;
      end else if (pick < 5) begin
        churn($urandom_range(20, 60));
      end else if (pick < 7) begin
        fill_up();
      end else if (pick < 8) begin
        noise($urandom_range(10, 25));
      end else begin
        drain();
        new_pool();
      end
    end

    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    churn(TAIL_ITEMS);
    drain();
    repeat (ENTRIES + 8) @(posedge clk_i);

    if (ledger.due.size() != 0)
      ledger.report($sformatf("%0d responses never arrived", ledger.due.size()));
    if (ledger.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
